[src/mfs_pkg.sv]
package mfs_pkg;

  // operation codes of an input item
  localparam logic [2:0] OP_WRITE_R = 3'd0;
  localparam logic [2:0] OP_WRITE_P = 3'd1;
  localparam logic [2:0] OP_WRITE_Q = 3'd2;
  localparam logic [2:0] OP_RUN     = 3'd3;
  localparam logic [2:0] OP_READ_P  = 3'd4;
  localparam logic [2:0] OP_READ_Q  = 3'd5;

  // configuration register indexes (byte address / 4)
  localparam logic [2:0] REG_LEARN_RATE = 3'd0;
  localparam logic [2:0] REG_REG_WEIGHT = 3'd1;
  localparam logic [2:0] REG_MAX_ITER   = 3'd2;
  localparam logic [2:0] REG_TOLERANCE  = 3'd3;
  localparam logic [2:0] REG_ROWS       = 3'd4;
  localparam logic [2:0] REG_COLS       = 3'd5;
  localparam logic [2:0] REG_FEATURES   = 3'd6;

  // register reset values
  localparam logic [15:0] LEARN_RATE_RST = 16'd1311;
  localparam logic [15:0] REG_WEIGHT_RST = 16'd66;
  localparam logic [15:0] MAX_ITER_RST   = 16'd5000;
  localparam logic [31:0] TOLERANCE_RST  = 32'd4295;
  localparam logic [4:0]  SIZE_RST       = 5'd10;

  // size and loop counter width, covers matrix dimensions up to 127
  localparam int SIZE_W = 7;

  localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

[src/matrix_factorization_sgd.sv]
// Matrix factorisation by SGD over three on-chip stores (R, P, Q), Q15.16 arithmetic.
// A read item waits on the registered store read. A run goes pass by pass; for every
// cell it forms the dot product over the nf features in use, and for a cell whose rating
// is above zero also the squared error and the P and Q updates of each feature; a final
// state then sets the result. The steps are serialised by the single shared 33x33
// multiplier, which serves dot product, squared error and both factor updates, and
// by the one read port of each store. The block takes no new item while it works.
module matrix_factorization_sgd #(
  parameter int MAX_ROWS     = 16,
  parameter int MAX_COLS     = 16,
  parameter int MAX_FEATURES = 16
) (
  input  logic               clk,
  input  logic               rst,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic [3:0]         row_index,
  input  logic [3:0]         col_index,
  input  logic signed [31:0] entry_value,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] read_value,
  output logic [15:0]        passes_done,
  output logic               converged,
  output logic [62:0]        final_error,
  output logic               status
);

  localparam int SW     = mfs_pkg::SIZE_W;
  localparam int R_DEP  = MAX_ROWS * MAX_COLS;
  localparam int P_DEP  = MAX_ROWS * MAX_FEATURES;
  localparam int Q_DEP  = MAX_FEATURES * MAX_COLS;
  localparam int R_AW   = (R_DEP > 1) ? $clog2(R_DEP) : 1;
  localparam int P_AW   = (P_DEP > 1) ? $clog2(P_DEP) : 1;
  localparam int Q_AW   = (Q_DEP > 1) ? $clog2(Q_DEP) : 1;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_RDWAIT = 5'd1;
  localparam logic [4:0] ST_PASS   = 5'd2;
  localparam logic [4:0] ST_CELL   = 5'd3;
  localparam logic [4:0] ST_CELL2  = 5'd4;
  localparam logic [4:0] ST_DRD    = 5'd5;
  localparam logic [4:0] ST_DMUL   = 5'd6;
  localparam logic [4:0] ST_DACC   = 5'd7;
  localparam logic [4:0] ST_ERR    = 5'd8;
  localparam logic [4:0] ST_SQ     = 5'd9;
  localparam logic [4:0] ST_SQADD  = 5'd10;
  localparam logic [4:0] ST_URD    = 5'd11;
  localparam logic [4:0] ST_ULD    = 5'd12;
  localparam logic [4:0] ST_G1     = 5'd13;
  localparam logic [4:0] ST_G2     = 5'd14;
  localparam logic [4:0] ST_G3     = 5'd15;
  localparam logic [4:0] ST_G4     = 5'd16;
  localparam logic [4:0] ST_G5     = 5'd17;
  localparam logic [4:0] ST_G6     = 5'd18;
  localparam logic [4:0] ST_NEXT   = 5'd19;
  localparam logic [4:0] ST_PEND   = 5'd20;
  localparam logic [4:0] ST_DONE   = 5'd21;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // configuration registers
  logic [15:0] learn_rate, reg_weight, max_iterations;
  logic [31:0] tolerance;
  logic [4:0]  rows_in_use, cols_in_use, features_in_use;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate      <= mfs_pkg::LEARN_RATE_RST;
      reg_weight      <= mfs_pkg::REG_WEIGHT_RST;
      max_iterations  <= mfs_pkg::MAX_ITER_RST;
      tolerance       <= mfs_pkg::TOLERANCE_RST;
      rows_in_use     <= mfs_pkg::SIZE_RST;
      cols_in_use     <= mfs_pkg::SIZE_RST;
      features_in_use <= mfs_pkg::SIZE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        mfs_pkg::REG_LEARN_RATE: learn_rate      <= pwdata[15:0];
        mfs_pkg::REG_REG_WEIGHT: reg_weight      <= pwdata[15:0];
        mfs_pkg::REG_MAX_ITER:   max_iterations  <= pwdata[15:0];
        mfs_pkg::REG_TOLERANCE:  tolerance       <= pwdata;
        mfs_pkg::REG_ROWS:       rows_in_use     <= pwdata[4:0];
        mfs_pkg::REG_COLS:       cols_in_use     <= pwdata[4:0];
        mfs_pkg::REG_FEATURES:   features_in_use <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      mfs_pkg::REG_LEARN_RATE: prdata = {16'd0, learn_rate};
      mfs_pkg::REG_REG_WEIGHT: prdata = {16'd0, reg_weight};
      mfs_pkg::REG_MAX_ITER:   prdata = {16'd0, max_iterations};
      mfs_pkg::REG_TOLERANCE:  prdata = tolerance;
      mfs_pkg::REG_ROWS:       prdata = {27'd0, rows_in_use};
      mfs_pkg::REG_COLS:       prdata = {27'd0, cols_in_use};
      mfs_pkg::REG_FEATURES:   prdata = {27'd0, features_in_use};
      default:                 prdata = 32'd0;
    endcase
  end

  // sizes clamped to the store dimensions
  logic [SW-1:0] nr, nc, nf;
  assign nr = (32'(rows_in_use) > MAX_ROWS) ? SW'(MAX_ROWS) : SW'(rows_in_use);
  assign nc = (32'(cols_in_use) > MAX_COLS) ? SW'(MAX_COLS) : SW'(cols_in_use);
  assign nf = (32'(features_in_use) > MAX_FEATURES) ? SW'(MAX_FEATURES)
                                                     : SW'(features_in_use);

  // sequencer state
  logic [4:0]         state;
  logic [SW-1:0]      i_cnt, j_cnt, k_cnt;
  logic [15:0]        n_cnt;
  logic               which;
  logic               rd_is_q;
  logic signed [55:0] acc;
  logic signed [31:0] r_val, e_val, p_old, q_old;
  logic signed [64:0] g;
  logic signed [65:0] t_lo;
  logic [63:0]        err_sum;
  logic [15:0]        pass_cnt;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [31:0] self_v, other_v;
  logic signed [64:0] g16;
  logic signed [32:0] g_lo, g_hi;
  logic signed [65:0] d_full, d_val;
  logic signed [31:0] new_v;

  assign self_v  = which ? q_old : p_old;
  assign other_v = which ? p_old : q_old;
  assign g16     = g >>> 16;
  assign g_lo    = $signed({9'd0, g16[23:0]});
  assign g_hi    = $signed({{8{g16[48]}}, g16[48:24]});
  assign d_full  = (prod <<< 24) + t_lo;
  assign d_val   = d_full >>> 15;
  assign new_v   = sat32(66'(self_v) + d_val);

  // stores
  logic signed [31:0] r_mem [R_DEP];
  logic signed [31:0] p_mem [P_DEP];
  logic signed [31:0] q_mem [Q_DEP];
  logic signed [31:0] r_rdata, p_rdata, q_rdata;
  logic [R_AW-1:0]    r_addr_in, r_addr_run;
  logic [P_AW-1:0]    p_addr_in, p_addr_run, p_raddr, p_waddr;
  logic [Q_AW-1:0]    q_addr_in, q_addr_run, q_raddr, q_waddr;
  logic               r_we, p_we, q_we;
  logic signed [31:0] p_wdata, q_wdata;

  always_comb begin
    unique case (state)
      ST_DMUL: begin mul_a = 33'(p_rdata);          mul_b = 33'(q_rdata); end
      ST_SQ:   begin mul_a = 33'(e_val);            mul_b = 33'(e_val); end
      ST_G1:   begin mul_a = 33'(e_val);            mul_b = 33'(other_v); end
      ST_G2:   begin mul_a = $signed({17'd0, reg_weight}); mul_b = 33'(self_v); end
      ST_G4:   begin mul_a = g_lo;                  mul_b = $signed({17'd0, learn_rate}); end
      ST_G5:   begin mul_a = g_hi;                  mul_b = $signed({17'd0, learn_rate}); end
      default: begin mul_a = 33'sd0;                mul_b = 33'sd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // handshake
  logic in_acc, out_free, idx_ok;
  logic [SW-1:0] ri, ci;
  assign ri       = SW'(row_index);
  assign ci       = SW'(col_index);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    unique case (operation) inside
      mfs_pkg::OP_WRITE_R:                      idx_ok = (ri < nr) && (ci < nc);
      mfs_pkg::OP_WRITE_P, mfs_pkg::OP_READ_P:  idx_ok = (ri < nr) && (ci < nf);
      mfs_pkg::OP_WRITE_Q, mfs_pkg::OP_READ_Q:  idx_ok = (ri < nf) && (ci < nc);
      default:                                  idx_ok = 1'b0;
    endcase
  end

  // store addressing
  assign r_addr_in  = R_AW'(32'(row_index) * MAX_COLS + 32'(col_index));
  assign p_addr_in  = P_AW'(32'(row_index) * MAX_FEATURES + 32'(col_index));
  assign q_addr_in  = Q_AW'(32'(row_index) * MAX_COLS + 32'(col_index));
  assign r_addr_run = R_AW'(32'(i_cnt) * MAX_COLS + 32'(j_cnt));
  assign p_addr_run = P_AW'(32'(i_cnt) * MAX_FEATURES + 32'(k_cnt));
  assign q_addr_run = Q_AW'(32'(k_cnt) * MAX_COLS + 32'(j_cnt));

  assign p_raddr = (state == ST_IDLE) ? p_addr_in : p_addr_run;
  assign q_raddr = (state == ST_IDLE) ? q_addr_in : q_addr_run;
  assign p_waddr = (state == ST_IDLE) ? p_addr_in : p_addr_run;
  assign q_waddr = (state == ST_IDLE) ? q_addr_in : q_addr_run;
  assign p_wdata = (state == ST_IDLE) ? entry_value : new_v;
  assign q_wdata = (state == ST_IDLE) ? entry_value : new_v;

  assign r_we = in_acc && idx_ok && (operation == mfs_pkg::OP_WRITE_R);
  assign p_we = (in_acc && idx_ok && (operation == mfs_pkg::OP_WRITE_P))
             || (state == ST_G6 && !which);
  assign q_we = (in_acc && idx_ok && (operation == mfs_pkg::OP_WRITE_Q))
             || (state == ST_G6 && which);

  always_ff @(posedge clk) begin
    if (r_we) r_mem[r_addr_in] <= entry_value;
    r_rdata <= r_mem[r_addr_run];
  end

  always_ff @(posedge clk) begin
    if (p_we) p_mem[p_waddr] <= p_wdata;
    p_rdata <= p_mem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    q_rdata <= q_mem[q_raddr];
  end

  // pass arithmetic helpers
  logic signed [31:0] pred;
  logic signed [31:0] e_next;
  logic [63:0]        sq;
  logic               last_k, last_j, last_i, below_tol;
  assign pred      = sat32(66'(acc));
  assign e_next    = sat32(66'(r_val) - 66'(pred));
  assign sq        = prod[63:0];
  assign last_k    = (SW'(k_cnt + 1'b1) == nf);
  assign last_j    = (SW'(j_cnt + 1'b1) == nc);
  assign last_i    = (SW'(i_cnt + 1'b1) == nr);
  assign below_tol = err_sum < {32'd0, tolerance};

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      err_sum   <= 64'd0;
      pass_cnt  <= 16'd0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            read_value  <= 32'sd0;
            passes_done <= 16'd0;
            converged   <= 1'b0;
            final_error <= 63'd0;
            status      <= !idx_ok && (operation != mfs_pkg::OP_RUN);
            rd_is_q     <= (operation == mfs_pkg::OP_READ_Q);
            if (operation == mfs_pkg::OP_RUN) begin
              n_cnt <= 16'd0;
              if (max_iterations == 16'd0) begin
                out_valid <= 1'b1;
                err_sum   <= 64'd0;
                pass_cnt  <= 16'd0;
              end else begin
                state <= ST_PASS;
              end
            end else if (idx_ok && (operation == mfs_pkg::OP_READ_P ||
                                    operation == mfs_pkg::OP_READ_Q)) begin
              state <= ST_RDWAIT;
            end else begin
              out_valid <= 1'b1;
            end
          end
        end
        ST_RDWAIT: begin
          read_value <= rd_is_q ? q_rdata : p_rdata;
          out_valid  <= 1'b1;
          state      <= ST_IDLE;
        end
        ST_PASS: begin
          i_cnt   <= '0;
          j_cnt   <= '0;
          err_sum <= 64'd0;
          state   <= (nr == '0 || nc == '0) ? ST_PEND : ST_CELL;
        end
        ST_CELL: begin
          acc   <= '0;
          k_cnt <= '0;
          state <= ST_CELL2;
        end
        ST_CELL2: begin
          r_val <= r_rdata;
          state <= (nf == '0) ? ST_ERR : ST_DRD;
        end
        // dot product, one feature at a time through the read, multiply and accumulate states
        ST_DRD:  state <= ST_DMUL;
        ST_DMUL: state <= ST_DACC;
        ST_DACC: begin
          acc   <= acc + 56'(prod >>> 16);
          k_cnt <= SW'(k_cnt + 1'b1);
          state <= last_k ? ST_ERR : ST_DRD;
        end
        ST_ERR: begin
          e_val <= e_next;
          state <= (r_val <= 32'sd0) ? ST_NEXT : ST_SQ;
        end
        ST_SQ: state <= ST_SQADD;
        ST_SQADD: begin
          err_sum <= (sq > mfs_pkg::SUM_MAX - err_sum) ? mfs_pkg::SUM_MAX : err_sum + sq;
          k_cnt   <= '0;
          which   <= 1'b0;
          state   <= (nf == '0) ? ST_NEXT : ST_URD;
        end
        // factor update, P then Q for each feature
        ST_URD: state <= ST_ULD;
        ST_ULD: begin
          p_old <= p_rdata;
          q_old <= q_rdata;
          state <= ST_G1;
        end
        ST_G1: state <= ST_G2;
        ST_G2: begin
          g     <= $signed(prod[64:0]);
          state <= ST_G3;
        end
        ST_G3: begin
          g     <= g - $signed(prod[64:0]);
          state <= ST_G4;
        end
        ST_G4: state <= ST_G5;
        ST_G5: begin
          t_lo  <= prod;
          state <= ST_G6;
        end
        ST_G6: begin
          if (!which) begin
            which <= 1'b1;
            state <= ST_G1;
          end else begin
            which <= 1'b0;
            k_cnt <= SW'(k_cnt + 1'b1);
            state <= last_k ? ST_NEXT : ST_URD;
          end
        end
        ST_NEXT: begin
          if (last_j) begin
            j_cnt <= '0;
            i_cnt <= SW'(i_cnt + 1'b1);
            state <= last_i ? ST_PEND : ST_CELL;
          end else begin
            j_cnt <= SW'(j_cnt + 1'b1);
            state <= ST_CELL;
          end
        end
        ST_PEND: begin
          n_cnt <= n_cnt + 16'd1;
          if (below_tol || (n_cnt + 16'd1 >= max_iterations)) begin
            converged <= below_tol;
            state     <= ST_DONE;
          end else begin
            state <= ST_PASS;
          end
        end
        ST_DONE: begin
          passes_done <= n_cnt;
          final_error <= err_sum[62:0];
          pass_cnt    <= n_cnt;
          out_valid   <= 1'b1;
          state       <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[dv/tb.sv]
module tb;

  localparam int     WATCHDOG_LIMIT = 400000;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] read_value;
    logic [15:0] passes_done;
    logic        converged;
    logic [62:0] final_error;
    logic        status;
  } result_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] operation = '0;
  logic [3:0] row_index = '0, col_index = '0;
  logic signed [31:0] entry_value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] read_value;
  logic [15:0] passes_done;
  logic converged;
  logic [62:0] final_error;
  logic status;

  matrix_factorization_sgd DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
    .row_index(row_index), .col_index(col_index), .entry_value(entry_value),
    .out_valid(out_valid), .out_stall(out_stall), .read_value(read_value),
    .passes_done(passes_done), .converged(converged),
    .final_error(final_error), .status(status)
  );

  initial forever #1 clk = ~clk;

  // shadow copy of the block state
  int rating_m[256];
  int row_fac_m[256];
  int col_fac_m[256];
  int learn_m, weight_m, iter_m, rows_m, cols_m, feat_m;
  logic [31:0] tol_m;

  result_t expected_q[$];
  int errors = 0;
  bit idle_en = 0;
  bit stall_en = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  function automatic int sat32(longint v);
    if (v > I32_MAX) return int'(I32_MAX);
    if (v < I32_MIN) return int'(I32_MIN);
    return int'(v);
  endfunction

  // one factor update, from the old values of both factors
  function automatic int sgd_step(int self_v, int other_v, int e);
    longint g, d;
    g = longint'(e) * longint'(other_v) - longint'(weight_m) * longint'(self_v);
    d = ((g >>> 16) * longint'(learn_m)) >>> 15;
    return sat32(longint'(self_v) + d);
  endfunction

  function automatic logic [63:0] sgd_pass(int nr, int nc, int nf);
    logic [63:0] sum, sq;
    longint acc;
    int pred, e, p, q;
    sum = '0;
    for (int i = 0; i < nr; i++)
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nf; k++)
          acc += (longint'(row_fac_m[i*16+k]) * longint'(col_fac_m[k*16+j])) >>> 16;
        pred = sat32(acc);
        if (rating_m[i*16+j] <= 0) continue;
        e = sat32(longint'(rating_m[i*16+j]) - longint'(pred));
        sq = 64'(longint'(e) * longint'(e));
        sum = (sq > mfs_pkg::SUM_MAX - sum) ? mfs_pkg::SUM_MAX : sum + sq;
        for (int k = 0; k < nf; k++) begin
          p = row_fac_m[i*16+k];
          q = col_fac_m[k*16+j];
          row_fac_m[i*16+k] = sgd_step(p, q, e);
          col_fac_m[k*16+j] = sgd_step(q, p, e);
        end
      end
    return sum;
  endfunction

  function automatic result_t predict_result(logic [2:0] op, int ri, int ci, int v);
    result_t r;
    int nr, nc, nf, n;
    logic [63:0] sum;
    bit done;
    r = '0;
    nr = rows_m > 16 ? 16 : rows_m;
    nc = cols_m > 16 ? 16 : cols_m;
    nf = feat_m > 16 ? 16 : feat_m;
    case (op)
      mfs_pkg::OP_WRITE_R: if (ri < nr && ci < nc) rating_m[ri*16+ci] = v;
                           else r.status = 1;
      mfs_pkg::OP_WRITE_P: if (ri < nr && ci < nf) row_fac_m[ri*16+ci] = v;
                           else r.status = 1;
      mfs_pkg::OP_WRITE_Q: if (ri < nf && ci < nc) col_fac_m[ri*16+ci] = v;
                           else r.status = 1;
      mfs_pkg::OP_READ_P: if (ri < nr && ci < nf) r.read_value = row_fac_m[ri*16+ci];
                          else r.status = 1;
      mfs_pkg::OP_READ_Q: if (ri < nf && ci < nc) r.read_value = col_fac_m[ri*16+ci];
                          else r.status = 1;
      mfs_pkg::OP_RUN: begin
        n = 0;
        sum = '0;
        done = 0;
        while (n < iter_m && !done) begin
          sum = sgd_pass(nr, nc, nf);
          n++;
          if (sum < {32'b0, tol_m}) done = 1;
        end
        r.passes_done = n[15:0];
        r.converged = done;
        r.final_error = sum[62:0];
      end
      default: r.status = 1;
    endcase
    return r;
  endfunction

  // result checking
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {read_value, passes_done, converged, final_error, status};
      if (expected_q.size() == 0) begin
        if (errors < 10) $display("unexpected result %h", got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          if (errors < 10)
            $display("mismatch: rd %h/%h passes %0d/%0d conv %b/%b err %h/%h st %b/%b",
                     want.read_value, got.read_value, want.passes_done, got.passes_done,
                     want.converged, got.converged, want.final_error, got.final_error,
                     want.status, got.status);
          errors++;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else if (hold_cycles > 0) begin
      out_stall <= 1;
      hold_cycles--;
    end else out_stall <= stall_en && ($urandom_range(99) < 28);
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int small_val();
    return int'($urandom_range(0, 131072)) - 65536;
  endfunction

  task automatic send_item(logic [2:0] op, int ri, int ci, int v);
    if (idle_en && $urandom_range(99) < 28) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1;
    operation <= op;
    row_index <= ri[3:0];
    col_index <= ci[3:0];
    entry_value <= v;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_result(op, ri, ci, v));
  endtask

  // wait for every outstanding result, then let the block settle
  task automatic drain();
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    case (idx)
      mfs_pkg::REG_LEARN_RATE: learn_m = value[15:0];
      mfs_pkg::REG_REG_WEIGHT: weight_m = value[15:0];
      mfs_pkg::REG_MAX_ITER:   iter_m = value[15:0];
      mfs_pkg::REG_TOLERANCE:  tol_m = value;
      mfs_pkg::REG_ROWS:       rows_m = value[4:0];
      mfs_pkg::REG_COLS:       cols_m = value[4:0];
      mfs_pkg::REG_FEATURES:   feat_m = value[4:0];
      default: ;
    endcase
  endtask

  task automatic set_sizes(int nr, int nc, int nf);
    cfg_write(mfs_pkg::REG_ROWS, nr);
    cfg_write(mfs_pkg::REG_COLS, nc);
    cfg_write(mfs_pkg::REG_FEATURES, nf);
  endtask

  task automatic set_run(int lr, int wt, int iters, logic [31:0] tol);
    cfg_write(mfs_pkg::REG_LEARN_RATE, lr);
    cfg_write(mfs_pkg::REG_REG_WEIGHT, wt);
    cfg_write(mfs_pkg::REG_MAX_ITER, iters);
    cfg_write(mfs_pkg::REG_TOLERANCE, tol);
  endtask

  // every entry of all three stores gets a value first
  task automatic test_fill();
    set_sizes(16, 16, 16);
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 16; j++) begin
        send_item(mfs_pkg::OP_WRITE_R, i, j, int'($urandom_range(0, 6)) * 32768 - 65536);
        send_item(mfs_pkg::OP_WRITE_P, i, j, small_val());
        send_item(mfs_pkg::OP_WRITE_Q, i, j, small_val());
      end
    drain();
  endtask

  task automatic test_edges();
    set_sizes(3, 3, 2);
    send_item(mfs_pkg::OP_WRITE_P, 0, 0, 32'h7FFF_FFFF);
    send_item(mfs_pkg::OP_WRITE_Q, 1, 2, 32'h8000_0000);
    send_item(mfs_pkg::OP_READ_P, 0, 0, 0);
    send_item(mfs_pkg::OP_READ_Q, 1, 2, 0);
    send_item(mfs_pkg::OP_WRITE_R, 2, 2, 32'h0003_0000);
    send_item(mfs_pkg::OP_WRITE_R, 3, 0, 1);
    send_item(mfs_pkg::OP_WRITE_P, 0, 2, 1);
    send_item(mfs_pkg::OP_WRITE_Q, 2, 0, 1);
    send_item(mfs_pkg::OP_READ_P, 3, 0, 0);
    send_item(mfs_pkg::OP_READ_Q, 0, 3, 0);
    send_item(3'd6, 15, 15, -1);
    send_item(3'd7, 0, 0, 0);
    drain();
  endtask

  task automatic test_run_settings();
    // largest learning rate and zero tolerance, so no convergence possible; then a zero rate
    set_sizes(2, 2, 2);
    set_run(65535, 0, 3, 0);
    send_item(mfs_pkg::OP_RUN, 0, 0, 0);
    drain();
    set_run(0, 65535, 1, 32'hFFFF_FFFF);
    send_item(mfs_pkg::OP_RUN, 0, 0, 0);
    drain();
    // single cell converging on its first pass despite the largest limit
    set_sizes(1, 1, 1);
    send_item(mfs_pkg::OP_WRITE_R, 0, 0, 32'h0000_8000);
    send_item(mfs_pkg::OP_WRITE_P, 0, 0, 0);
    send_item(mfs_pkg::OP_WRITE_Q, 0, 0, 0);
    drain();
    set_run(1311, 66, 65535, 32'hFFFF_FFFF);
    send_item(mfs_pkg::OP_RUN, 0, 0, 0);
    drain();
    // no pass at all
    cfg_write(mfs_pkg::REG_MAX_ITER, 0);
    send_item(mfs_pkg::OP_RUN, 0, 0, 0);
    drain();
    // empty matrix
    set_sizes(0, 0, 0);
    set_run(1311, 66, 2, 0);
    send_item(mfs_pkg::OP_WRITE_R, 0, 0, 5);
    send_item(mfs_pkg::OP_READ_P, 0, 0, 0);
    send_item(mfs_pkg::OP_RUN, 0, 0, 0);
    drain();
    // oversized registers clamp to the full store, one full pass
    set_sizes(31, 31, 31);
    set_run(1311, 66, 1, 4295);
    send_item(mfs_pkg::OP_RUN, 0, 0, 0);
    send_item(mfs_pkg::OP_READ_Q, 15, 15, 0);
    drain();
  endtask

  task automatic test_backpressure();
    set_sizes(4, 4, 4);
    hold_cycles = 400;
    for (int n = 0; n < 12; n++)
      send_item($urandom_range(1) ? mfs_pkg::OP_READ_P : mfs_pkg::OP_WRITE_Q,
                $urandom_range(3), $urandom_range(3), small_val());
    drain();
  endtask

  task automatic test_random();
    int x, lim;
    logic [2:0] op;
    for (int ph = 0; ph < 10; ph++) begin
      idle_en = ph >= 3;
      stall_en = ph >= 3;
      set_sizes($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4));
      set_run($urandom_range(65535), $urandom_range(1) ? $urandom_range(65535) : 66,
              $urandom_range(1, 6), $urandom_range(1) ? $urandom : $urandom_range(100000));
      lim = (rows_m > cols_m ? rows_m : cols_m) + 1;
      for (int n = 0; n < 40; n++) begin
        x = $urandom_range(99);
        if (x < 18) op = mfs_pkg::OP_WRITE_R;
        else if (x < 30) op = mfs_pkg::OP_WRITE_P;
        else if (x < 42) op = mfs_pkg::OP_WRITE_Q;
        else if (x < 47) op = mfs_pkg::OP_RUN;
        else if (x < 70) op = mfs_pkg::OP_READ_P;
        else if (x < 94) op = mfs_pkg::OP_READ_Q;
        else op = 3'($urandom_range(6, 7));
        send_item(op,
                  $urandom_range(99) < 40 ? $urandom_range(15) : $urandom_range(lim),
                  $urandom_range(99) < 40 ? $urandom_range(15) : $urandom_range(lim),
                  $urandom_range(99) < 15 ? int'($urandom) : small_val());
      end
      drain();
    end
  endtask

  initial begin
    rating_m = '{default: 0};
    row_fac_m = '{default: 0};
    col_fac_m = '{default: 0};
    learn_m = mfs_pkg::LEARN_RATE_RST;
    weight_m = mfs_pkg::REG_WEIGHT_RST;
    iter_m = mfs_pkg::MAX_ITER_RST;
    tol_m = mfs_pkg::TOLERANCE_RST;
    rows_m = mfs_pkg::SIZE_RST;
    cols_m = mfs_pkg::SIZE_RST;
    feat_m = mfs_pkg::SIZE_RST;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_fill();
    test_edges();
    test_run_settings();
    idle_en = 1;
    stall_en = 1;
    test_backpressure();
    test_random();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
